### rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types, constants and the per-sequence decode function.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Most code units one input item can produce.
  localparam int unsigned MAX_UNITS   = 4;
  // Default depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] REPL_CHAR     = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SUPPL_BASE    = 21'h10000;
  localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
  localparam logic [7:0]  LEAD2_MIN     = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX     = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN     = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX     = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN     = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX     = 8'hF4;
  localparam logic [7:0]  LEAD_E0       = 8'hE0;
  localparam logic [7:0]  LEAD_ED       = 8'hED;
  localparam logic [7:0]  LEAD_F0       = 8'hF0;
  localparam logic [7:0]  LEAD_F4       = 8'hF4;
  localparam logic [7:0]  E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0]  ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0]  F0_SECOND_MIN = 8'h90;
  localparam logic [7:0]  F4_SECOND_MAX = 8'h8F;

  typedef logic [7:0] octet_t;

  // One code unit as it leaves the block.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
  } unit_t;

  // All the code units caused by one input item.
  typedef struct packed {
    unit_t [MAX_UNITS-1:0] units;
    logic [2:0]            count;
    logic                  fin;
  } step_t;

  // Outcome of decoding the sequence at one buffer position.
  typedef struct packed {
    logic        stop;
    logic [2:0]  used;
    logic        err;
    logic [20:0] cp;
  } seq_t;

  // Number of bytes a lead byte calls for; bad leads count as one.
  function automatic logic [2:0] seq_length(input octet_t lead);
    logic [2:0] len;
    priority if (lead[7] == 1'b0)                           len = 3'd1;
    else if (lead >= LEAD2_MIN && lead <= LEAD2_MAX)        len = 3'd2;
    else if (lead >= LEAD3_MIN && lead <= LEAD3_MAX)        len = 3'd3;
    else if (lead >= LEAD4_MIN && lead <= LEAD4_MAX)        len = 3'd4;
    else                                                    len = 3'd1;
    return len;
  endfunction

  function automatic logic is_cont(input octet_t b);
    return b[7:6] == 2'b10;
  endfunction

  // Decode the sequence starting at b0 with avail bytes present.
  function automatic seq_t decode_seq(input octet_t b0, input octet_t b1,
                                      input octet_t b2, input octet_t b3,
                                      input logic [2:0] avail, input logic fin);
    seq_t       r;
    logic [2:0] need;
    need   = seq_length(b0);
    r.stop = !fin && (need > avail);
    r.used = 3'd1;
    r.err  = 1'b1;
    r.cp   = {5'd0, REPL_CHAR};
    priority if (b0[7] == 1'b0) begin
      r.err = 1'b0;
      r.cp  = {13'd0, b0};
    end else if (need == 3'd1 || avail < need) begin
      r.err = 1'b1;
    end else if (need == 3'd2) begin
      if (is_cont(b1)) begin
        r.used = 3'd2;
        r.err  = 1'b0;
        r.cp   = {10'd0, b0[4:0], b1[5:0]};
      end
    end else if (need == 3'd3) begin
      if (is_cont(b1) && is_cont(b2)
          && !(b0 == LEAD_E0 && b1 < E0_SECOND_MIN)
          && !(b0 == LEAD_ED && b1 > ED_SECOND_MAX)) begin
        r.used = 3'd3;
        r.err  = 1'b0;
        r.cp   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end
    end else begin
      if (is_cont(b1) && is_cont(b2) && is_cont(b3)
          && !(b0 == LEAD_F0 && b1 < F0_SECOND_MIN)
          && !(b0 == LEAD_F4 && b1 > F4_SECOND_MAX)) begin
        r.used = 3'd4;
        r.err  = 1'b0;
        r.cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end
    end
    return r;
  endfunction

endpackage

### rtl/u8u16_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder channel interfaces
// Byte input channel and code unit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        replaced;
  logic        last_of_run;
  logic        final_unit;

  modport source (output valid, output code_unit, output replaced,
                  output last_of_run, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input replaced,
                  input last_of_run, input final_unit, output ready);
endinterface

### rtl/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// The code units of an accepted byte are registered in the step queue, then sent.
// Throughput: one byte per cycle while each byte yields at most one code unit; the
// output port sends one unit per cycle while out_ready is high.
// The step queue (QUEUE_DEPTH items) lets input and output stall independently.
// Reset (rst_n low, synchronous) empties the queue and clears the pending bytes.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream into UTF-16 code units, replacing bad sequences.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);

  logic             acc;
  logic             push;
  logic             pop;
  logic             full;
  logic             head_valid;
  u8u16_pkg::step_t push_step;
  u8u16_pkg::step_t head_step;
  u8u16_pkg::unit_t out_unit;

  assign in_ch.ready = !full;
  assign acc         = in_ch.valid && !full;

  // Front: pending bytes and decode.
  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .push       (push),
    .step       (push_step)
  );

  // Queue between decode and output.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_step  (push_step),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_step  (head_step)
  );

  // Back: unit serializer.
  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_step  (head_step),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_unit   (out_unit),
    .out_last   (out_ch.last_of_run),
    .out_final  (out_ch.final_unit)
  );

  assign out_ch.code_unit = out_unit.code_unit;
  assign out_ch.replaced  = out_unit.replaced;

endmodule

### rtl/u8u16_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder front part
// Holds the pending bytes, decodes each accepted byte against them and
// forms the list of code units the item causes.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  u8u16_pkg::octet_t   data_byte,
  input  logic                final_byte,
  output logic                push,
  output u8u16_pkg::step_t    step
);

  u8u16_pkg::octet_t [2:0] pend_r, pend_nxt;
  logic [1:0]              pcnt_r, pcnt_nxt;

  u8u16_pkg::octet_t [3:0] buf_w;
  u8u16_pkg::octet_t [3:0] win;
  u8u16_pkg::seq_t         sq;
  u8u16_pkg::step_t        st;
  logic [2:0]              n;
  logic [2:0]              pos;
  logic [2:0]              k;
  logic [2:0]              idx;
  logic [2:0]              pidx;
  logic [2:0]              rem;
  logic                    done;
  logic [20:0]             off;

  // Merge pending bytes with the new byte into a four-byte window.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < {1'b0, pcnt_r}) buf_w[j] = pend_r[j[1:0]];
      else if (3'(j) == {1'b0, pcnt_r}) buf_w[j] = data_byte;
      else buf_w[j] = '0;
    end
    n = {1'b0, pcnt_r} + 3'd1;
  end

  // Walk the buffer one sequence at a time; at most four positions.
  always_comb begin
    st   = '0;
    pos  = '0;
    k    = '0;
    done = 1'b0;
    win  = '0;
    sq   = '0;
    off  = '0;
    idx  = '0;
    for (int i = 0; i < 4; i++) begin
      if (!done && pos < n) begin
        for (int j = 0; j < 4; j++) begin
          idx    = pos + 3'(j);
          win[j] = (idx < 3'd4) ? buf_w[idx[1:0]] : '0;
        end
        sq = u8u16_pkg::decode_seq(win[0], win[1], win[2], win[3], n - pos, final_byte);
        if (sq.stop) begin
          done = 1'b1;
        end else begin
          pos = pos + sq.used;
          if (sq.cp <= u8u16_pkg::BMP_MAX) begin
            if (k < 3'd4) begin
              st.units[k[1:0]].code_unit = sq.cp[15:0];
              st.units[k[1:0]].replaced  = sq.err;
            end
            k = k + 3'd1;
          end else begin
            off = sq.cp - u8u16_pkg::SUPPL_BASE;
            if (k < 3'd4) begin
              st.units[k[1:0]].code_unit = u8u16_pkg::HI_SURR_BASE + {6'd0, off[19:10]};
              st.units[k[1:0]].replaced  = 1'b0;
            end
            if (k < 3'd3) begin
              st.units[k[1:0] + 2'd1].code_unit =
                u8u16_pkg::LO_SURR_BASE + {6'd0, off[9:0]};
              st.units[k[1:0] + 2'd1].replaced  = 1'b0;
            end
            k = k + 3'd2;
          end
        end
      end
    end
    st.count = k;
    st.fin   = final_byte;
  end

  // Undecided bytes stay pending, oldest first.
  always_comb begin
    pidx = '0;
    rem  = n - pos;
    if (rem > 3'd3) rem = 3'd3;
    for (int j = 0; j < 3; j++) begin
      pidx        = pos + 3'(j);
      pend_nxt[j] = (3'(j) < rem && pidx < 3'd4) ? buf_w[pidx[1:0]] : '0;
    end
    pcnt_nxt = rem[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end else if (acc) begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  assign push = acc && (st.count != 3'd0);
  assign step = st;

endmodule

### rtl/u8u16_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder step queue
// Short register queue of decoded items between the front and back parts.
// ----------------------------------------------------------------------------
module u8u16_queue #(
  parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8u16_pkg::step_t push_step,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output u8u16_pkg::step_t head_step
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u8u16_pkg::step_t mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PTR_W'(1);
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PTR_W'(1);
    if (push && !pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage: no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_step;
  end

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_step  = mem[rd_r];

endmodule

### rtl/u8u16_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder back part
// Sends the code units of the queued item one per handshake and marks the
// last unit of each item and of the text.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  u8u16_pkg::step_t head_step,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output u8u16_pkg::unit_t out_unit,
  output logic             out_last,
  output logic             out_final
);

  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid = head_valid;
  assign fire      = head_valid && out_ready;
  assign out_unit  = head_step.units[idx_r];
  assign out_last  = ({1'b0, idx_r} == head_step.count - 3'd1);
  assign out_final = out_last && head_step.fin;
  assign pop       = fire && out_last;

  // Step through the units of the head item.
  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = out_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule
